[hdl/frpm_pkg.sv]
// Shared constants, types and helper functions of the flash request performance monitor.
// Used by frpm_div, flash_request_perf_monitor and frpm_checker. No dependencies.
package frpm_pkg;

  // Geometry and widths
  localparam int NUM_CHANNELS      = 8;
  localparam int CHIPS_PER_CHANNEL = 8;
  localparam int NUM_UNITS         = NUM_CHANNELS * CHIPS_PER_CHANNEL;
  localparam int UNIT_BITS         = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
  localparam int COUNT_BITS        = 32;
  localparam int DELTA_BITS        = 24;
  localparam int NUM_TYPES         = 10;
  localparam int NUM_MEANS         = 12;
  localparam int MEAN_IDX_BITS     = 4;

  // Port field widths
  localparam int CMD_W     = 2;
  localparam int TYPE_W    = 4;
  localparam int UNIT_W    = 8;
  localparam int FDELTA_W  = 24;
  localparam int FCOUNT_W  = 32;
  localparam int FAVG_W    = 24;
  localparam int S_DATA_W  = 40;
  localparam int M_DATA_W  = 120;

  // Divider widths: divisor is counter + 1, partial remainder one bit wider
  localparam int DIVISOR_BITS = COUNT_BITS + 1;
  localparam int REM_BITS     = COUNT_BITS + 2;
  localparam int DIV_CNT_BITS = (DELTA_BITS > 1) ? $clog2(DELTA_BITS) : 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_COUNT = 2'd0,
    CMD_SW    = 2'd1,
    CMD_QUEUE = 2'd2,
    CMD_TOTAL = 2'd3
  } cmd_t;

  // Request types
  localparam logic [TYPE_W-1:0] T_RD      = 4'd0;
  localparam logic [TYPE_W-1:0] T_WR      = 4'd1;
  localparam logic [TYPE_W-1:0] T_RMW_RD  = 4'd2;
  localparam logic [TYPE_W-1:0] T_RMW_WR  = 4'd3;
  localparam logic [TYPE_W-1:0] T_GC_RD   = 4'd4;
  localparam logic [TYPE_W-1:0] T_GC_WR   = 4'd5;
  localparam logic [TYPE_W-1:0] T_META_RD = 4'd7;
  localparam logic [TYPE_W-1:0] T_META_WR = 4'd8;
  localparam logic [TYPE_W-1:0] T_GC_RUN  = 4'd9;

  // Mean kinds
  localparam logic [1:0] KIND_TOTAL = 2'd2;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOOK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic rem_nz;
  } div_status_t;

  // Mean class of a request type
  typedef struct packed {
    logic       ok;
    logic [1:0] cls;
  } mean_class_t;

  function automatic mean_class_t mean_class(logic [TYPE_W-1:0] t);
    mean_class_t mc;
    mc = '{ok: 1'b0, cls: 2'd0};
    case (t)
      T_RD:     mc = '{ok: 1'b1, cls: 2'd0};
      T_WR:     mc = '{ok: 1'b1, cls: 2'd1};
      T_RMW_RD: mc = '{ok: 1'b1, cls: 2'd2};
      T_GC_RUN: mc = '{ok: 1'b1, cls: 2'd3};
      default:  mc = '{ok: 1'b0, cls: 2'd0};
    endcase
    return mc;
  endfunction

  // Index into the mean table: class * 3 + kind
  function automatic logic [MEAN_IDX_BITS-1:0] mean_index(logic [1:0] cls, logic [1:0] kind);
    return {cls, 1'b0} + {2'b00, cls} + {2'b00, kind};
  endfunction

  function automatic logic is_read_type(logic [TYPE_W-1:0] t);
    return (t == T_RD) || (t == T_RMW_RD) || (t == T_GC_RD) || (t == T_META_RD);
  endfunction

  function automatic logic is_write_type(logic [TYPE_W-1:0] t);
    return (t == T_WR) || (t == T_RMW_WR) || (t == T_GC_WR) || (t == T_META_WR);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

[hdl/flash_request_perf_monitor.sv]
// Flash request performance monitor: event counters and running latency means.
// Depends on frpm_pkg, frpm_ram and frpm_div.
//
//  channel | dir | handshake         | contents
//  s_*     | in  | s_tvalid/s_tready | tuser: command; tdata: req_kind, unit_id, delta_us
//  m_*     | out | m_tvalid/m_tready | tuser: unit_ok; tdata: counts and average_us
//
// A count or a latency command with no mean passes through the lookup and output
// states before it loads the result register; a latency command with a mean also
// passes through the divide state, where it waits for the bit-serial divider.
// One item is in work at a time; s_tready is low during reset.
// Reset clears all counters and means at once (per-unit valid bits); no sweep.
// A waiting result does not block the next input transfer; a new result waits
// in the output state, with s_tready low, until the output register is free.
module flash_request_perf_monitor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [frpm_pkg::CMD_W-1:0]    s_tuser,   // [1:0] command
  input  logic [frpm_pkg::S_DATA_W-1:0] s_tdata,   // [3:0] req_kind, [11:4] unit_id,
                                                   // [35:12] delta_us, [39:36] zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic                          m_tuser,   // [0] unit_ok
  output logic [frpm_pkg::M_DATA_W-1:0] m_tdata    // [31:0] type_count,
                                                   // [63:32] unit_read_count,
                                                   // [95:64] unit_write_count,
                                                   // [119:96] average_us
);

  localparam int CB = frpm_pkg::COUNT_BITS;
  localparam int DB = frpm_pkg::DELTA_BITS;

  frpm_pkg::state_t state;

  // latched item
  logic [frpm_pkg::CMD_W-1:0]  cmd_q;
  logic [frpm_pkg::TYPE_W-1:0] type_q;
  logic [frpm_pkg::UNIT_W-1:0] unit_q;
  logic [DB-1:0]               delta_q;

  // state stores
  logic [CB-1:0]                type_counters [frpm_pkg::NUM_TYPES];
  logic [DB-1:0]                latency_means [frpm_pkg::NUM_MEANS];
  logic [frpm_pkg::NUM_UNITS-1:0] unit_valid;

  // result being assembled
  logic [CB-1:0] res_count;
  logic [CB-1:0] res_rd;
  logic [CB-1:0] res_wr;
  logic [DB-1:0] res_avg;
  logic          res_uok;

  // mean update context
  logic [frpm_pkg::MEAN_IDX_BITS-1:0] mean_idx;
  logic [DB-1:0]                      avg_cur;
  logic                               up_dir;

  // unit RAM: {write count, read count}
  logic                           ram_we;
  logic [frpm_pkg::UNIT_BITS-1:0] ram_raddr;
  logic [2*CB-1:0]                ram_wdata;
  logic [2*CB-1:0]                ram_rdata;

  // divider
  logic                              div_start;
  logic [DB-1:0]                     div_dividend;
  logic [frpm_pkg::DIVISOR_BITS-1:0] div_divisor;
  logic [DB-1:0]                     div_quo;
  frpm_pkg::div_status_t             div_st;

  logic s_xfer;
  logic out_free;

  assign s_tready = !rst && (state == frpm_pkg::ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign ram_raddr = s_tdata[4 +: frpm_pkg::UNIT_BITS];

  frpm_ram #(
    .WIDTH(2 * frpm_pkg::COUNT_BITS),
    .DEPTH(frpm_pkg::NUM_UNITS)
  ) u_unit_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(unit_q[frpm_pkg::UNIT_BITS-1:0]),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  frpm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .quotient(div_quo),
    .status  (div_st)
  );

  // lookup decode, valid in ST_LOOK
  logic                   type_ok;
  logic                   uok;
  frpm_pkg::mean_class_t  mc;
  logic [CB-1:0]          cur_type;
  logic [CB-1:0]          cur_rd;
  logic [CB-1:0]          cur_wr;
  logic [CB-1:0]          new_type;
  logic [CB-1:0]          new_rd;
  logic [CB-1:0]          new_wr;
  logic                   do_count;
  logic                   do_mean;
  logic                   bump_rd;
  logic                   bump_wr;
  logic [frpm_pkg::MEAN_IDX_BITS-1:0] lat_idx;
  logic [frpm_pkg::MEAN_IDX_BITS-1:0] tot_idx;
  logic [DB-1:0]          lat_avg;

  always_comb begin
    type_ok  = type_q < frpm_pkg::TYPE_W'(frpm_pkg::NUM_TYPES);
    uok      = {1'b0, unit_q} < 9'(frpm_pkg::NUM_UNITS);
    mc       = frpm_pkg::mean_class(type_q);
    cur_type = type_ok ? type_counters[type_q] : '0;
    if (uok && unit_valid[unit_q[frpm_pkg::UNIT_BITS-1:0]]) begin
      cur_rd = ram_rdata[CB-1:0];
      cur_wr = ram_rdata[2*CB-1:CB];
    end else begin
      cur_rd = '0;
      cur_wr = '0;
    end
    do_count = type_ok && (cmd_q == frpm_pkg::CMD_COUNT);
    do_mean  = type_ok && (cmd_q != frpm_pkg::CMD_COUNT) && mc.ok;
    bump_rd  = do_count && uok && frpm_pkg::is_read_type(type_q);
    bump_wr  = do_count && uok && frpm_pkg::is_write_type(type_q);
    new_type = do_count ? frpm_pkg::sat_inc(cur_type) : cur_type;
    new_rd   = bump_rd ? frpm_pkg::sat_inc(cur_rd) : cur_rd;
    new_wr   = bump_wr ? frpm_pkg::sat_inc(cur_wr) : cur_wr;
    lat_idx  = frpm_pkg::mean_index(mc.cls, cmd_q - 1'b1);
    tot_idx  = frpm_pkg::mean_index(mc.cls, frpm_pkg::KIND_TOTAL);
    lat_avg  = latency_means[lat_idx];
    ram_we    = (state == frpm_pkg::ST_LOOK) && (bump_rd || bump_wr);
    ram_wdata = {new_wr, new_rd};
    div_start = (state == frpm_pkg::ST_LOOK) && do_mean;
    div_dividend = (delta_q >= lat_avg) ? (delta_q - lat_avg) : (lat_avg - delta_q);
    div_divisor  = {1'b0, cur_type} + 1'b1;
  end

  // mean result when the divider finishes
  logic [DB-1:0] new_mean;
  always_comb begin
    if (up_dir) begin
      new_mean = avg_cur + div_quo;
    end else begin
      new_mean = avg_cur - div_quo - DB'(div_st.rem_nz);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frpm_pkg::ST_IDLE;
    end else begin
      case (state)
        frpm_pkg::ST_IDLE: begin
          if (s_xfer) state <= frpm_pkg::ST_LOOK;
        end
        frpm_pkg::ST_LOOK: begin
          state <= do_mean ? frpm_pkg::ST_DIV : frpm_pkg::ST_OUT;
        end
        frpm_pkg::ST_DIV: begin
          if (div_st.done) state <= frpm_pkg::ST_OUT;
        end
        frpm_pkg::ST_OUT: begin
          if (out_free) state <= frpm_pkg::ST_IDLE;
        end
        default: state <= frpm_pkg::ST_IDLE;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      cmd_q   <= s_tuser;
      type_q  <= s_tdata[3:0];
      unit_q  <= s_tdata[11:4];
      delta_q <= DB'(s_tdata[35:12]);
    end
  end

  // type counters and unit valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < frpm_pkg::NUM_TYPES; i++) type_counters[i] <= '0;
      unit_valid <= '0;
    end else if (state == frpm_pkg::ST_LOOK) begin
      if (do_count) type_counters[type_q] <= new_type;
      if (ram_we) unit_valid[unit_q[frpm_pkg::UNIT_BITS-1:0]] <= 1'b1;
    end
  end

  // latency means
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < frpm_pkg::NUM_MEANS; i++) latency_means[i] <= '0;
    end else if ((state == frpm_pkg::ST_DIV) && div_st.done) begin
      latency_means[mean_idx] <= new_mean;
    end
  end

  // result assembly
  always_ff @(posedge clk) begin
    if (state == frpm_pkg::ST_LOOK) begin
      res_count <= new_type;
      res_rd    <= new_rd;
      res_wr    <= new_wr;
      res_uok   <= uok;
      res_avg   <= (do_count && mc.ok) ? latency_means[tot_idx] : '0;
      mean_idx  <= lat_idx;
      avg_cur   <= lat_avg;
      up_dir    <= delta_q >= lat_avg;
    end else if ((state == frpm_pkg::ST_DIV) && div_st.done) begin
      res_avg <= new_mean;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == frpm_pkg::ST_OUT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == frpm_pkg::ST_OUT) && out_free) begin
      m_tuser <= res_uok;
      m_tdata <= {frpm_pkg::FAVG_W'(res_avg),
                  frpm_pkg::FCOUNT_W'(res_wr),
                  frpm_pkg::FCOUNT_W'(res_rd),
                  frpm_pkg::FCOUNT_W'(res_count)};
    end
  end

endmodule

[hdl/frpm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frpm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/frpm_div.sv]
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on frpm_pkg.
module frpm_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [frpm_pkg::DELTA_BITS-1:0]   dividend,
  input  logic [frpm_pkg::DIVISOR_BITS-1:0] divisor,
  output logic [frpm_pkg::DELTA_BITS-1:0]   quotient,
  output frpm_pkg::div_status_t             status
);

  logic                              busy;
  logic                              done;
  logic [frpm_pkg::DIV_CNT_BITS-1:0] cnt;
  logic [frpm_pkg::REM_BITS-1:0]     rem;
  logic [frpm_pkg::DELTA_BITS-1:0]   quo;
  logic [frpm_pkg::DIVISOR_BITS-1:0] dvsr;

  logic [frpm_pkg::REM_BITS-1:0]     trial;
  logic                              take;

  // trial subtract of the shifted partial remainder
  always_comb begin
    trial = {rem[frpm_pkg::REM_BITS-2:0], quo[frpm_pkg::DELTA_BITS-1]};
    take  = trial >= {1'b0, dvsr};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= frpm_pkg::DIV_CNT_BITS'(frpm_pkg::DELTA_BITS - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out at the top, quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= take ? (trial - {1'b0, dvsr}) : trial;
      quo <= {quo[frpm_pkg::DELTA_BITS-2:0], take};
    end
  end

  assign quotient      = quo;
  assign status.busy   = busy;
  assign status.done   = done;
  assign status.rem_nz = (rem != '0);

endmodule

[hdl/frpm_checker.sv]
// Port-level checks of the flash request performance monitor, bound to the top level.
// Depends on frpm_pkg and flash_request_perf_monitor.
module frpm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [frpm_pkg::CMD_W-1:0]    s_tuser,
  input logic [frpm_pkg::S_DATA_W-1:0] s_tdata,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic                          m_tuser,
  input logic [frpm_pkg::M_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while an item is in work");

  // an out-of-range unit reports zero unit counters
  a_bad_unit_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[95:32] == '0)
    else $error("unit counters nonzero for an invalid unit");

  // no result in the cycle after a reset cycle
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a result never rises right after an input transfer
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result appeared too soon after an input transfer");

endmodule

bind flash_request_perf_monitor frpm_checker u_frpm_checker (.*);
